>>> sv/cks_pkg.sv
// Package for the cost key sorter: field widths, defaults, the sequencer
// state type and the store write request. No dependencies.
package cks_pkg;

    localparam int DEF_MAX_ENTRIES = 64;
    localparam int COST_W          = 32;
    localparam int TAG_W           = 6;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INS_RD,
        ST_INS_CMP,
        ST_INS_FIN,
        ST_DR_RD,
        ST_DR_LD,
        ST_DR_WAIT
    } t_state;

    // One write into the pair store; the address travels beside it.
    typedef struct packed {
        logic                     we;
        logic signed [COST_W-1:0] key;
        logic [TAG_W-1:0]         tag;
    } t_wr_req;

endpackage

>>> sv/cks_store.sv
// Pair store of the cost key sorter: one write port and one registered
// read port over the key and tag memories. Depends on cks_pkg.
module cks_store
    import cks_pkg::*;
#(
    parameter int MAX_ENTRIES = DEF_MAX_ENTRIES,
    localparam int AW = $clog2(MAX_ENTRIES)
) (
    input  logic                     i_clk,
    input  t_wr_req                  i_wr,
    input  logic [AW-1:0]            i_waddr,
    input  logic [AW-1:0]            i_raddr,
    output logic signed [COST_W-1:0] o_rkey,
    output logic [TAG_W-1:0]         o_rtag
);

    logic signed [COST_W-1:0] r_key_mem [MAX_ENTRIES];
    logic [TAG_W-1:0]         r_tag_mem [MAX_ENTRIES];

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            r_key_mem[i_waddr] <= i_wr.key;
            r_tag_mem[i_waddr] <= i_wr.tag;
        end
    end

    // Read port, data registered.
    always_ff @(posedge i_clk) begin
        o_rkey <= r_key_mem[i_raddr];
        o_rtag <= r_tag_mem[i_raddr];
    end

endmodule

>>> sv/cks_ctrl.sv
// Sequencer of the cost key sorter: insertion of each loaded item with one
// shared compare, then the drain. Depends on cks_pkg and drives cks_store.
module cks_ctrl
    import cks_pkg::*;
#(
    parameter int MAX_ENTRIES = DEF_MAX_ENTRIES,
    localparam int AW = $clog2(MAX_ENTRIES),
    localparam int CW = $clog2(MAX_ENTRIES + 1)
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // Input items.
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic signed [COST_W-1:0] i_cost_value,
    input  logic [TAG_W-1:0]         i_individual_tag,
    input  logic                     i_last_item,
    // Result items.
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic signed [COST_W-1:0] o_sorted_cost,
    output logic [TAG_W-1:0]         o_sorted_tag,
    output logic                     o_end_of_run,
    output logic                     o_overflow_flag,
    // Store ports.
    output t_wr_req                  o_wr,
    output logic [AW-1:0]            o_waddr,
    output logic [AW-1:0]            o_raddr,
    input  logic signed [COST_W-1:0] i_rkey,
    input  logic [TAG_W-1:0]         i_rtag
);

    localparam logic [CW-1:0] FULL_COUNT = CW'(MAX_ENTRIES);

    t_state                   r_state, n_state;
    logic [CW-1:0]            r_count, n_count;
    logic                     r_dropped, n_dropped;
    logic [AW-1:0]            r_pos, n_pos;
    logic signed [COST_W-1:0] r_key, n_key;
    logic [TAG_W-1:0]         r_tag, n_tag;
    logic                     r_last, n_last;
    logic                     r_out_valid, n_out_valid;
    logic signed [COST_W-1:0] r_out_cost, n_out_cost;
    logic [TAG_W-1:0]         r_out_tag, n_out_tag;
    logic                     r_out_end, n_out_end;
    logic                     r_out_ovf, n_out_ovf;
    logic                     key_less;
    logic                     at_end;

    // The shared compare: new key strictly below the stored one keeps ties stable.
    assign key_less = r_key < i_rkey;
    assign at_end   = (CW'(r_pos) == CW'(r_count - 1'b1));

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_dropped   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_dropped   <= n_dropped;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_pos      <= n_pos;
        r_key      <= n_key;
        r_tag      <= n_tag;
        r_last     <= n_last;
        r_out_cost <= n_out_cost;
        r_out_tag  <= n_out_tag;
        r_out_end  <= n_out_end;
        r_out_ovf  <= n_out_ovf;
    end

    // Next state and store requests.
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_dropped   = r_dropped;
        n_pos       = r_pos;
        n_key       = r_key;
        n_tag       = r_tag;
        n_last      = r_last;
        n_out_valid = r_out_valid;
        n_out_cost  = r_out_cost;
        n_out_tag   = r_out_tag;
        n_out_end   = r_out_end;
        n_out_ovf   = r_out_ovf;
        o_wr.we     = 1'b0;
        o_wr.key    = r_key;
        o_wr.tag    = r_tag;
        o_waddr     = r_pos;
        o_raddr     = r_pos;

        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_key  = i_cost_value;
                    n_tag  = i_individual_tag;
                    n_last = i_last_item;
                    if (r_count == FULL_COUNT) begin
                        // Store full: the item is dropped and marked.
                        n_dropped = 1'b1;
                        n_pos     = '0;
                        if (i_last_item) begin
                            n_state = ST_DR_RD;
                        end
                    end else begin
                        n_pos   = r_count[AW-1:0];
                        n_state = (r_count == '0) ? ST_INS_FIN : ST_INS_RD;
                    end
                end
            end
            ST_INS_RD: begin
                o_raddr = r_pos - 1'b1;
                n_state = ST_INS_CMP;
            end
            ST_INS_CMP: begin
                if (key_less) begin
                    // Shift the larger pair up one place.
                    o_wr.we  = 1'b1;
                    o_wr.key = i_rkey;
                    o_wr.tag = i_rtag;
                    n_pos    = r_pos - 1'b1;
                    n_state  = (r_pos == AW'(1)) ? ST_INS_FIN : ST_INS_RD;
                end else begin
                    n_state = ST_INS_FIN;
                end
            end
            ST_INS_FIN: begin
                o_wr.we = 1'b1;
                n_count = r_count + 1'b1;
                n_pos   = '0;
                n_state = r_last ? ST_DR_RD : ST_IDLE;
            end
            ST_DR_RD: begin
                n_state = ST_DR_LD;
            end
            ST_DR_LD: begin
                n_out_valid = 1'b1;
                n_out_cost  = i_rkey;
                n_out_tag   = i_rtag;
                n_out_end   = at_end;
                n_out_ovf   = r_dropped;
                n_state     = ST_DR_WAIT;
            end
            ST_DR_WAIT: begin
                if (i_out_ready) begin
                    n_out_valid = 1'b0;
                    if (r_out_end) begin
                        n_count   = '0;
                        n_dropped = 1'b0;
                        n_state   = ST_IDLE;
                    end else begin
                        n_pos   = r_pos + 1'b1;
                        n_state = ST_DR_RD;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_in_ready      = (r_state == ST_IDLE);
    assign o_out_valid     = r_out_valid;
    assign o_sorted_cost   = r_out_cost;
    assign o_sorted_tag    = r_out_tag;
    assign o_end_of_run    = r_out_end;
    assign o_overflow_flag = r_out_ovf;

endmodule

>>> sv/cost_key_sorter_core.sv
// Top level of the cost key sorter: stable ascending sort of (cost, tag)
// pairs. Depends on cks_pkg, cks_store and cks_ctrl.
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+----------------------------------
//  input    | i_in_valid / o_in_ready    | cost_value, individual_tag, last
//  result   | o_out_valid / i_out_ready  | sorted_cost, sorted_tag, end, ovf
//
// A loaded item is written straight in ST_INS_FIN when the store is empty;
// else ST_INS_RD reads the pair below and ST_INS_CMP shifts it up while the
// new key is lower, until the bottom or a compare stops it, then ST_INS_FIN
// writes it, all through the single store read port and compare. A dropped
// item is only marked. Each result is read, loaded, then held until taken.
// Reset clears the fill count and drop mark; the store needs no clearing.
// The input is not ready while an item is inserted or the run is drained.
module cost_key_sorter_core
    import cks_pkg::*;
#(
    parameter int MAX_ENTRIES = DEF_MAX_ENTRIES
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic signed [COST_W-1:0] i_cost_value,
    input  logic [TAG_W-1:0]         i_individual_tag,
    input  logic                     i_last_item,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic signed [COST_W-1:0] o_sorted_cost,
    output logic [TAG_W-1:0]         o_sorted_tag,
    output logic                     o_end_of_run,
    output logic                     o_overflow_flag
);

    localparam int AW = $clog2(MAX_ENTRIES);

    t_wr_req                  wr;
    logic [AW-1:0]            waddr;
    logic [AW-1:0]            raddr;
    logic signed [COST_W-1:0] rkey;
    logic [TAG_W-1:0]         rtag;

    // Sequencer with the shared compare.
    cks_ctrl #(
        .MAX_ENTRIES(MAX_ENTRIES)
    ) u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_cost_value    (i_cost_value),
        .i_individual_tag(i_individual_tag),
        .i_last_item     (i_last_item),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_sorted_cost   (o_sorted_cost),
        .o_sorted_tag    (o_sorted_tag),
        .o_end_of_run    (o_end_of_run),
        .o_overflow_flag (o_overflow_flag),
        .o_wr            (wr),
        .o_waddr         (waddr),
        .o_raddr         (raddr),
        .i_rkey          (rkey),
        .i_rtag          (rtag)
    );

    // Pair store.
    cks_store #(
        .MAX_ENTRIES(MAX_ENTRIES)
    ) u_store (
        .i_clk  (i_clk),
        .i_wr   (wr),
        .i_waddr(waddr),
        .i_raddr(raddr),
        .o_rkey (rkey),
        .o_rtag (rtag)
    );

endmodule
